### rtl/sacn_pkg.sv
// shared types and constants for the set-associative nru cache lookup
// no dependencies; imported by every rtl module of the block except sacn_ram
`default_nettype none
package sacn_pkg;

    localparam int TAG_W   = 32;
    localparam int MISS_W  = 32;
    localparam int CFG_W   = 4;
    localparam int EFF_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index codes, taken from paddr[2]
    localparam logic REG_INDEX_BITS  = 1'b0;
    localparam logic REG_WAYS_IN_USE = 1'b1;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET  = 4'd6;
    localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = 4'd4;

    // effective geometry after clamping
    typedef struct packed {
        logic [EFF_W-1:0] index_bits;
        logic [EFF_W-1:0] ways;
    } cfg_t;

endpackage
`default_nettype wire

### rtl/set_assoc_cache_nru_lookup.sv
// top level of the set-associative cache lookup with one-bit nru replacement
// depends on sacn_pkg, sacn_ram, sacn_cfg, sacn_decide
// tag/state rams are read at accept; stage 1 compares and writes back, and the result is
// registered from it; throughput one transaction per cycle while out_ready does not hold the output
// reset: after rst_n releases, a clearing pass writes the valid/nru state ram one set
// per cycle over every set; in_ready stays low until it ends
// registers reset to index_bit_count 6, ways_in_use 4; miss count to zero
`default_nettype none
module set_assoc_cache_nru_lookup
    import sacn_pkg::*;
#(
    parameter int MAX_INDEX_BITS  = 10,
    parameter int MAX_WAYS        = 8,
    parameter int BLOCK_ADDR_BITS = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [PADDR_W-1:0]         paddr,
    input  wire logic [PDATA_W-1:0]         pwdata,
    output logic      [PDATA_W-1:0]         prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [BLOCK_ADDR_BITS-1:0] blk_addr,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            hit,
    output logic      [MISS_W-1:0]          miss_total
);
    localparam int IDX_W = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam int SETS  = 1 << MAX_INDEX_BITS;
    localparam int XW    = (BLOCK_ADDR_BITS > TAG_W) ? BLOCK_ADDR_BITS : TAG_W;
    localparam int ST_W  = 2 * MAX_WAYS;

    cfg_t cfg;

    sacn_cfg #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .MAX_WAYS       (MAX_WAYS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- input side: split address into set and tag ----------------
    logic [XW-1:0]    addr_x;
    logic [XW-1:0]    addr_shift;
    logic [IDX_W-1:0] idx_mask;
    logic [IDX_W-1:0] in_set;
    logic [TAG_W-1:0] in_tag;
    logic             in_fire;

    assign addr_x     = XW'(blk_addr);
    assign addr_shift = addr_x >> cfg.index_bits;
    assign in_tag     = addr_shift[TAG_W-1:0];

    always_comb
    begin
        for (int i = 0; i < IDX_W; i++)
        begin
            idx_mask[i] = EFF_W'(i) < cfg.index_bits;
        end
    end

    assign in_set  = addr_x[IDX_W-1:0] & idx_mask;
    assign in_fire = in_valid & in_ready;

    // ---------------- clearing pass over the state ram ----------------
    logic             clr_busy_reg, clr_busy_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
            if (clr_idx_reg == IDX_W'(SETS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    // ---------------- stage 1 registers ----------------
    logic             s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0] s1_set_reg;
    logic [TAG_W-1:0] s1_tag_reg;
    logic             s1_adv;
    logic             out_free;

    assign out_free = ~out_valid | out_ready;
    assign s1_adv   = s1_valid_reg & out_free;
    assign in_ready = ~clr_busy_reg & (~s1_valid_reg | s1_adv);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_set_reg <= in_set;
            s1_tag_reg <= in_tag;
        end
    end

    // ---------------- rams: one tag ram per way, one state ram for valid/nru ----------------
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_rd;
    logic [ST_W-1:0]                state_rd;
    logic                           state_we;
    logic [IDX_W-1:0]               state_waddr;
    logic [ST_W-1:0]                state_wdata;
    logic [MAX_WAYS-1:0]            tag_we;

    logic                           dec_hit;
    logic [MAX_WAYS-1:0]            victim_oh;
    logic [MAX_WAYS-1:0]            valid_new;
    logic [MAX_WAYS-1:0]            nru_new;

    for (genvar w = 0; w < MAX_WAYS; w++)
    begin : g_tag
        assign tag_we[w] = s1_adv & ~dec_hit & victim_oh[w];

        sacn_ram #(
            .WIDTH (TAG_W),
            .DEPTH (SETS)
        ) u_tag_ram (
            .clk   (clk),
            .we    (tag_we[w]),
            .waddr (s1_set_reg),
            .wdata (s1_tag_reg),
            .re    (in_fire),
            .raddr (in_set),
            .rdata (tag_rd[w])
        );
    end

    // clear pass writes valid zero, nru one; otherwise stage 1 writes back
    always_comb
    begin
        if (clr_busy_reg)
        begin
            state_we    = 1'b1;
            state_waddr = clr_idx_reg;
            state_wdata = {{MAX_WAYS{1'b1}}, {MAX_WAYS{1'b0}}};
        end
        else
        begin
            state_we    = s1_adv;
            state_waddr = s1_set_reg;
            state_wdata = {nru_new, valid_new};
        end
    end

    sacn_ram #(
        .WIDTH (ST_W),
        .DEPTH (SETS)
    ) u_state_ram (
        .clk   (clk),
        .we    (state_we),
        .waddr (state_waddr),
        .wdata (state_wdata),
        .re    (in_fire),
        .raddr (in_set),
        .rdata (state_rd)
    );

    // ---------------- write forwarding ----------------
    // a read issued on the same edge as a write to the same set sees old data;
    // the last write is kept here and overrides the ram output for that set
    logic                fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]    fwd_set_reg;
    logic [ST_W-1:0]     fwd_state_reg;
    logic [MAX_WAYS-1:0] fwd_way_reg;
    logic [TAG_W-1:0]    fwd_tag_reg;
    logic                fwd_match;

    assign fwd_valid_next = fwd_valid_reg | s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            fwd_set_reg   <= s1_set_reg;
            fwd_state_reg <= {nru_new, valid_new};
            fwd_way_reg   <= dec_hit ? '0 : victim_oh;
            fwd_tag_reg   <= s1_tag_reg;
        end
    end

    assign fwd_match = fwd_valid_reg & (fwd_set_reg == s1_set_reg);

    logic [MAX_WAYS-1:0][TAG_W-1:0] way_tags;
    logic [ST_W-1:0]                state_cur;

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_tags[w] = (fwd_match & fwd_way_reg[w]) ? fwd_tag_reg : tag_rd[w];
        end
    end

    assign state_cur = fwd_match ? fwd_state_reg : state_rd;

    sacn_decide #(
        .MAX_WAYS (MAX_WAYS)
    ) u_decide (
        .cfg       (cfg),
        .tag       (s1_tag_reg),
        .way_tags  (way_tags),
        .valid_in  (state_cur[MAX_WAYS-1:0]),
        .nru_in    (state_cur[ST_W-1:MAX_WAYS]),
        .hit       (dec_hit),
        .victim_oh (victim_oh),
        .valid_out (valid_new),
        .nru_out   (nru_new)
    );

    // ---------------- miss counter and result register ----------------
    logic [MISS_W-1:0] miss_reg, miss_next;
    logic              out_valid_reg, out_valid_next;
    logic              hit_reg;
    logic [MISS_W-1:0] miss_total_reg;

    always_comb
    begin
        miss_next = miss_reg;
        if (s1_adv & ~dec_hit & (miss_reg != '1))
        begin
            miss_next = miss_reg + MISS_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            hit_reg        <= dec_hit;
            miss_total_reg <= miss_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign miss_total = miss_total_reg;
endmodule
`default_nettype wire

### rtl/sacn_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module sacn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/sacn_cfg.sv
// apb configuration registers and clamping to the effective geometry
// depends on sacn_pkg
`default_nettype none
module sacn_cfg
    import sacn_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 10,
    parameter int MAX_WAYS       = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);
    logic [CFG_W-1:0] index_bits_reg, index_bits_next;
    logic [CFG_W-1:0] ways_reg, ways_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        index_bits_next = index_bits_reg;
        ways_next       = ways_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_INDEX_BITS:  index_bits_next = pwdata[CFG_W-1:0];
                REG_WAYS_IN_USE: ways_next       = pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= INDEX_BITS_RESET;
            ways_reg       <= WAYS_IN_USE_RESET;
        end
        else
        begin
            index_bits_reg <= index_bits_next;
            ways_reg       <= ways_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_INDEX_BITS:  prdata = PDATA_W'(index_bits_reg);
            REG_WAYS_IN_USE: prdata = PDATA_W'(ways_reg);
            default:         prdata = '0;
        endcase
    end

    // clamp: index count to the built maximum, ways to 1..max
    always_comb
    begin
        if ({1'b0, index_bits_reg} > EFF_W'(MAX_INDEX_BITS))
        begin
            cfg.index_bits = EFF_W'(MAX_INDEX_BITS);
        end
        else
        begin
            cfg.index_bits = {1'b0, index_bits_reg};
        end
        if (ways_reg == '0)
        begin
            cfg.ways = EFF_W'(1);
        end
        else if ({1'b0, ways_reg} > EFF_W'(MAX_WAYS))
        begin
            cfg.ways = EFF_W'(MAX_WAYS);
        end
        else
        begin
            cfg.ways = {1'b0, ways_reg};
        end
    end
endmodule
`default_nettype wire

### rtl/sacn_decide.sv
// per-set way compare, hit detection and nru victim selection
// depends on sacn_pkg
`default_nettype none
module sacn_decide
    import sacn_pkg::*;
#(
    parameter int MAX_WAYS = 8
) (
    input  wire cfg_t                            cfg,
    input  wire logic [TAG_W-1:0]                tag,
    input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]  way_tags,
    input  wire logic [MAX_WAYS-1:0]             valid_in,
    input  wire logic [MAX_WAYS-1:0]             nru_in,
    output logic                                 hit,
    output logic      [MAX_WAYS-1:0]             victim_oh,
    output logic      [MAX_WAYS-1:0]             valid_out,
    output logic      [MAX_WAYS-1:0]             nru_out
);
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] hit_oh;
    logic [MAX_WAYS-1:0] cand;
    logic [MAX_WAYS-1:0] cand_oh;
    logic [MAX_WAYS-1:0] way0_oh;

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w] = EFF_W'(w) < cfg.ways;
            match[w]  = in_use[w] & valid_in[w] & (way_tags[w] == tag);
        end
    end

    assign way0_oh = MAX_WAYS'(1);
    assign hit     = |match;
    // lowest set bit isolates the first matching / first not-recent way
    assign hit_oh  = match & (~match + MAX_WAYS'(1));
    assign cand    = in_use & nru_in;
    assign cand_oh = cand & (~cand + MAX_WAYS'(1));

    always_comb
    begin
        victim_oh = '0;
        valid_out = valid_in;
        nru_out   = nru_in;
        if (hit)
        begin
            nru_out = nru_in & ~hit_oh;
        end
        else if (|cand)
        begin
            victim_oh = cand_oh;
            valid_out = valid_in | cand_oh;
            nru_out   = nru_in & ~cand_oh;
        end
        else
        begin
            // every way in use recently used: reset marks, replace way 0
            victim_oh = way0_oh;
            valid_out = valid_in | way0_oh;
            nru_out   = (nru_in | in_use) & ~way0_oh;
        end
    end
endmodule
`default_nettype wire

### verif/tb_top.sv
// self-checking testbench for set_assoc_cache_nru_lookup: directed and random block addresses
// against an in-bench nru cache predictor, with apb geometry changes and random flow control
// depends on sacn_pkg and the rtl top level only
`default_nettype none
module tb_top;
    import sacn_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int CLK_PERIOD     = 2 * HALF_PERIOD;
    localparam int TB_INDEX_MAX   = 10;
    localparam int TB_WAYS_MAX    = 8;
    localparam int ENTRY_COUNT    = (1 << TB_INDEX_MAX) * TB_WAYS_MAX;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 40;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int TAG_POOL_SIZE  = 6;

    // register byte addresses, derived from the package register codes
    localparam logic [PADDR_W-1:0] ADDR_INDEX_BITS  = {REG_INDEX_BITS, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_WAYS_IN_USE = {REG_WAYS_IN_USE, 2'b00};

    // one predicted lookup outcome
    typedef struct packed {
        logic              hit;
        logic [MISS_W-1:0] miss_total;
    } lookup_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // apb side
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // reference stream side
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [31:0] blk_addr      = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        hit;
    logic [MISS_W-1:0] miss_total;

    // predictor copy of the cache state and geometry
    logic [TAG_W-1:0]  tag_mem   [ENTRY_COUNT];
    bit                valid_mem [ENTRY_COUNT];
    bit                nru_mem   [ENTRY_COUNT];
    logic [MISS_W-1:0] model_misses;
    logic [CFG_W-1:0]  cfg_index_bits;
    logic [CFG_W-1:0]  cfg_ways;

    // lookups accepted by the block whose result has not come back yet
    lookup_result_t pending_lookups[$];

    int mismatch_count = 0;
    int burst_left     = 0;
    int hold_tickets   = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int stall_mode     = 0;
    int stall_left     = 0;
    logic [31:0] tag_pool [TAG_POOL_SIZE];

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    set_assoc_cache_nru_lookup u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .blk_addr      (blk_addr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .miss_total    (miss_total)
    );

    // one line per mismatch, capped so a broken run stays readable
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // cache predictor
    // ------------------------------------------------------------------

    // index count above the built maximum acts as the maximum
    function automatic int eff_index_bits();
        return (cfg_index_bits > TB_INDEX_MAX) ? TB_INDEX_MAX : int'(cfg_index_bits);
    endfunction

    // zero ways acts as one, above the built maximum acts as the maximum
    function automatic int eff_ways();
        if (cfg_ways == 0)
        begin
            return 1;
        end
        return (cfg_ways > TB_WAYS_MAX) ? TB_WAYS_MAX : int'(cfg_ways);
    endfunction

    task automatic reset_cache_model();
        for (int e = 0; e < ENTRY_COUNT; e++)
        begin
            tag_mem[e]   = '0;
            valid_mem[e] = 1'b0;
            nru_mem[e]   = 1'b1;
        end
        model_misses   = '0;
        cfg_index_bits = INDEX_BITS_RESET;
        cfg_ways       = WAYS_IN_USE_RESET;
    endtask

    // look one block address up, update the predicted state, return the outcome
    function automatic lookup_result_t predict_lookup(input logic [31:0] addr);
        int             ib;
        int             ways;
        int             base;
        int             victim;
        int             w;
        logic [31:0]    set_idx;
        logic [31:0]    tag;
        bit             was_hit;
        bit             found_free;
        lookup_result_t res;
        ib      = eff_index_bits();
        ways    = eff_ways();
        set_idx = addr & ((32'd1 << ib) - 32'd1);
        tag     = addr >> ib;
        base    = int'(set_idx) * TB_WAYS_MAX;
        was_hit = 1'b0;
        // lowest valid matching way wins when a tag is held twice
        for (w = 0; w < ways && !was_hit; w++)
        begin
            if (valid_mem[base + w] && tag_mem[base + w] == tag)
            begin
                was_hit           = 1'b1;
                nru_mem[base + w] = 1'b0;
            end
        end
        if (!was_hit)
        begin
            // saturating miss count
            if (model_misses != '1)
            begin
                model_misses = model_misses + MISS_W'(1);
            end
            found_free = 1'b0;
            victim     = 0;
            for (w = 0; w < ways && !found_free; w++)
            begin
                if (nru_mem[base + w])
                begin
                    victim     = w;
                    found_free = 1'b1;
                end
            end
            // every way recently used: set all marks again and take way 0
            if (!found_free)
            begin
                for (w = 0; w < ways; w++)
                begin
                    nru_mem[base + w] = 1'b1;
                end
                victim = 0;
            end
            tag_mem[base + victim]   = tag;
            valid_mem[base + victim] = 1'b1;
            nru_mem[base + victim]   = 1'b0;
        end
        res.hit        = was_hit;
        res.miss_total = model_misses;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly a few tags over a few sets so that hits, fills and nru wraps happen;
    // the rest is fully random, all zeros, all ones or single-bit patterns
    function automatic logic [31:0] gen_addr();
        int          pick;
        int          ib;
        logic [31:0] mask;
        logic [31:0] one_hot;
        ib   = eff_index_bits();
        mask = (32'd1 << ib) - 32'd1;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            return (tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)] << ib)
                 | (32'($urandom_range(0, 3)) & mask);
        end
        else if (pick < 90)
        begin
            return $urandom();
        end
        one_hot = 32'd1 << $urandom_range(0, 31);
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return one_hot;
            default: return ~one_hot;
        endcase
    endfunction

    // offer one address and hold it until the block takes it; valid is left high
    // so the caller either sends again in the same step or lowers it
    task automatic send_ref(input logic [31:0] addr);
        lookup_result_t expected;
        in_valid <= 1'b1;
        blk_addr <= addr;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expected        = predict_lookup(addr);
        pending_lookups = {pending_lookups, expected};
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // a run of random references, in random bursts or back to back
    task automatic stream_refs(input int count, input bit bursty);
        for (int n = 0; n < count; n++)
        begin
            send_ref(gen_addr());
            if (bursty)
            begin
                if (burst_left <= 0)
                begin
                    pause_sender($urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 5));
                    burst_left = $urandom_range(0, 30);
                end
                else
                begin
                    burst_left--;
                end
            end
        end
    endtask

    // sender goes quiet until every pending result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // one apb transfer; psel stays high so transfers can follow back to back
    task automatic apb_transfer(input bit is_write, input logic [PADDR_W-1:0] addr,
                                input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rdata = prdata;
    endtask

    // write both geometry registers while the block is idle and read them back
    task automatic set_geometry(input logic [CFG_W-1:0] index_bits,
                                input logic [CFG_W-1:0] ways);
        logic [PDATA_W-1:0] wdata;
        logic [PDATA_W-1:0] rdata;
        wait_drained();
        // random upper data bits, only the low nibble is a register
        wdata        = $urandom();
        wdata[3:0]   = index_bits;
        apb_transfer(1'b1, ADDR_INDEX_BITS, wdata, rdata);
        cfg_index_bits = index_bits;
        apb_transfer(1'b0, ADDR_INDEX_BITS, '0, rdata);
        if (rdata[CFG_W-1:0] !== index_bits)
        begin
            report_mismatch($sformatf("index_bit_count reads %0h, wrote %0h",
                                      rdata[CFG_W-1:0], index_bits));
        end
        wdata        = $urandom();
        wdata[3:0]   = ways;
        apb_transfer(1'b1, ADDR_WAYS_IN_USE, wdata, rdata);
        cfg_ways = ways;
        apb_transfer(1'b0, ADDR_WAYS_IN_USE, '0, rdata);
        if (rdata[CFG_W-1:0] !== ways)
        begin
            report_mismatch($sformatf("ways_in_use reads %0h, wrote %0h",
                                      rdata[CFG_W-1:0], ways));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern and checker
    // ------------------------------------------------------------------

    // receiver flow control: long hold-offs on request, otherwise changing stall modes
    always @(posedge clk)
    begin
        if (hold_served != hold_tickets)
        begin
            hold_served = hold_served + 1;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (stall_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(10, 80);
            end
            stall_left = stall_left - 1;
            case (stall_mode)
                0:       out_ready <= 1'b1;                          // no stalls
                1:       out_ready <= ($urandom_range(0, 3) != 0);   // light stalls
                2:       out_ready <= ($urandom_range(0, 9) < 3);    // heavy stalls
                default: out_ready <= (stall_left % 3 != 0);         // periodic
            endcase
        end
    end

    // every result transaction is compared with the oldest pending lookup
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result: hit=%0b miss_total=%0d",
                                          hit, miss_total));
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (hit !== want.hit)
                begin
                    report_mismatch($sformatf("hit %0b, predicted %0b (miss_total %0d)",
                                              hit, want.hit, want.miss_total));
                end
                if (miss_total !== want.miss_total)
                begin
                    report_mismatch($sformatf("miss_total %0d, predicted %0d",
                                              miss_total, want.miss_total));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register reset values, once the clearing pass has ended
    task automatic test_register_defaults();
        logic [PDATA_W-1:0] rdata;
        while (!in_ready)
        begin
            @(posedge clk);
        end
        apb_transfer(1'b0, ADDR_INDEX_BITS, '0, rdata);
        if (rdata[CFG_W-1:0] !== INDEX_BITS_RESET)
        begin
            report_mismatch($sformatf("index_bit_count resets to %0h", rdata[CFG_W-1:0]));
        end
        apb_transfer(1'b0, ADDR_WAYS_IN_USE, '0, rdata);
        if (rdata[CFG_W-1:0] !== WAYS_IN_USE_RESET)
        begin
            report_mismatch($sformatf("ways_in_use resets to %0h", rdata[CFG_W-1:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // address extremes, hit after fill, and an nru wrap in one set (reset geometry)
    task automatic test_directed_lookups();
        send_ref(32'h0000_0000);   // cold miss
        send_ref(32'h0000_0000);   // hit
        send_ref(32'hFFFF_FFFF);   // cold miss, all ones
        send_ref(32'hFFFF_FFFF);   // hit
        // five tags into set 3 with four ways: the fifth finds every way used
        for (int t = 1; t <= 5; t++)
        begin
            send_ref((32'(t) << 6) | 32'd3);
        end
        send_ref((32'd2 << 6) | 32'd3);   // still resident
        send_ref((32'd1 << 6) | 32'd3);   // was evicted by the wrap
        send_ref((32'd5 << 6) | 32'd3);
        send_ref(32'h8000_0000);
        send_ref(32'h0000_0001);
        send_ref(32'h7FFF_FFFF);
        send_ref(32'hAAAA_AAAA);
        send_ref(32'h5555_5555);
        send_ref(32'h8000_0000);
        wait_drained();
    endtask

    // shrink then widen the ways so one tag sits in two ways of a set
    task automatic test_duplicate_match();
        set_geometry(4'd0, 4'd2);
        send_ref(32'h0000_1111);   // way 0
        send_ref(32'h0000_2222);   // way 1
        set_geometry(4'd0, 4'd1);
        send_ref(32'h0000_2222);   // only way 0 in use: refills way 0
        set_geometry(4'd0, 4'd2);
        send_ref(32'h0000_2222);   // both ways hold it, lowest wins
        send_ref(32'h0000_1111);
        wait_drained();
    endtask

    // random references under a series of geometries, extremes and clamped values included
    task automatic test_geometry_sweep();
        logic [CFG_W-1:0] ib_list   [8] = '{4'd0, 4'd10, 4'd15, 4'd3, 4'd1, 4'd11, 4'd6, 4'd2};
        logic [CFG_W-1:0] ways_list [8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd9, 4'd3, 4'd5};
        for (int p = 0; p < 8; p++)
        begin
            set_geometry(ib_list[p], ways_list[p]);
            stream_refs(50, 1'b1);
            wait_drained();
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        set_geometry(4'd2, 4'd4);
        hold_tickets = hold_tickets + 1;
        stream_refs(100, 1'b0);
        wait_drained();
    endtask

    // sender stops until the block has returned every result, then resumes
    task automatic test_drain_pause();
        stream_refs(40, 1'b1);
        wait_drained();
        stream_refs(40, 1'b1);
        wait_drained();
    endtask

    // random geometry changes between random chunks, contents reinterpreted
    task automatic test_random_mix();
        for (int c = 0; c < 4; c++)
        begin
            tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)] = $urandom();
            set_geometry(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 4)),
                         4'($urandom_range(0, 15)));
            stream_refs(30, 1'b1);
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_cache_model();
        for (int i = 0; i < TAG_POOL_SIZE; i++)
        begin
            tag_pool[i] = $urandom();
        end
        tag_pool[0] = 32'h0000_0000;
        tag_pool[1] = 32'hFFFF_FFFF;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_register_defaults();
        test_directed_lookups();
        test_duplicate_match();
        test_geometry_sweep();
        test_output_backpressure();
        test_drain_pause();
        test_random_mix();

        // let the pipeline settle so any stray result transaction is caught
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_lookups.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("TIMEOUT: %0d lookups still pending", pending_lookups.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
rtl/sacn_pkg.sv
rtl/sacn_ram.sv
rtl/sacn_cfg.sv
rtl/sacn_decide.sv
rtl/set_assoc_cache_nru_lookup.sv
verif/tb_top.sv
